// File: rtl/assert_macros.svh
// Assertion macros used by the frame allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define FBA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define FBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/fba_pkg.sv
// Package for the frame bitmap allocator: sizes, codes and bit helpers.
package fba_pkg;

  localparam int unsigned NUM_FRAMES  = 65536;
  localparam int unsigned FRAME_BYTES = 4096;
  localparam int unsigned OFFSET_W    = $clog2(FRAME_BYTES);
  localparam int unsigned FRAME_W     = $clog2(NUM_FRAMES);
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BIT_W       = $clog2(WORD_BITS);
  localparam int unsigned WORDS       = NUM_FRAMES / WORD_BITS;
  localparam int unsigned WORD_AW     = $clog2(WORDS);
  localparam int unsigned SUM_WORDS   = WORDS / WORD_BITS;
  localparam int unsigned SUM_AW      = $clog2(SUM_WORDS);

  localparam int unsigned COUNT_W     = 17;
  localparam int unsigned ADDR_W      = 28;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_W       = 17;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 48;

  localparam logic [CFG_W-1:0] RESERVED_RESET = CFG_W'(256);

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Index of the lowest clear bit of a word (0 when none is clear).
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // Word whose bits base..base+31 are set where the bit index is below cnt.
  function automatic logic [WORD_BITS-1:0] fill_pattern(input logic [COUNT_W-1:0] base,
                                                        input logic [COUNT_W-1:0] cnt);
    logic [COUNT_W:0]     upper;
    logic [COUNT_W-1:0]   diff;
    logic [WORD_BITS-1:0] r;
    upper = {1'b0, base} + (COUNT_W + 1)'(WORD_BITS);
    diff  = cnt - base;
    if ({1'b0, cnt} >= upper) r = '1;
    else if (cnt <= base)     r = '0;
    else                      r = ~({WORD_BITS{1'b1}} << diff[BIT_W-1:0]);
    return r;
  endfunction

endpackage

// File: rtl/fba_ram.sv
// Generic simple dual-port RAM with registered read.
module fba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/frame_bitmap_allocator_top.sv
// Frame bitmap allocator: first-fit page frame allocator over a bitmap RAM.
//
// Input channel s_*: s_tuser carries the request kind (allocate, free, clear),
// s_tdata the byte address to free. Output channel m_*: one result item per
// request with frame address, status and the frame count in use afterwards.
// cfg_we/cfg_wdata set the number of reserved low frames used by a clear.
//
// One request is worked on at a time; s_tready is high only when idle. An
// allocate walks a 64-bit flop summary, one summary RAM word and one bitmap
// RAM word through a single read port each, so its work does not depend on
// how full the bitmap is; with every frame used it is refused without a RAM
// read. A clear (and reset) sweeps the 2048-word bitmap RAM one word per cycle.
//
// After reset the block runs the same sweep with 256 reserved frames and
// accepts no item until it ends; configuration writes are taken during it. A
// finished result waits in the output register while the receiver stalls;
// the next item may be accepted meanwhile, but its result is held back until
// the register is free.
`include "assert_macros.svh"

module frame_bitmap_allocator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fba_pkg::IN_DATA_W-1:0]     s_tdata,   // [31:0] free_address
  input  logic [1:0]                        s_tuser,   // [1:0] req_type
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [27:0] frame_address, [29:28] status, [46:30] used_count, [47] zero
  output logic [fba_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [fba_pkg::CFG_W-1:0]         cfg_wdata
);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_A_SRD,
    S_A_SDAT,
    S_A_BRD,
    S_A_BDAT,
    S_F_RD,
    S_F_DAT,
    S_DONE
  } state_t;

  state_t                                state;
  logic [fba_pkg::WORD_AW-1:0]           sweep_addr;
  logic                                  sweep_req;
  logic [fba_pkg::COUNT_W-1:0]           fill_n;
  logic [fba_pkg::SUM_WORDS-1:0]         top_full;
  logic [fba_pkg::COUNT_W-1:0]           count;
  logic [fba_pkg::CFG_W-1:0]             reserved;
  logic [fba_pkg::SUM_AW-1:0]            sum_idx;
  logic [fba_pkg::WORD_AW-1:0]           word_idx;
  logic [fba_pkg::WORD_BITS-1:0]         sum_word;
  logic [fba_pkg::FRAME_W-1:0]           free_frame;
  logic [fba_pkg::ADDR_W-1:0]            res_addr;
  fba_pkg::status_t                      res_status;

  // RAM ports
  logic                                  bm_we;
  logic [fba_pkg::WORD_AW-1:0]           bm_waddr;
  logic [fba_pkg::WORD_BITS-1:0]         bm_wdata;
  logic [fba_pkg::WORD_AW-1:0]           bm_raddr;
  logic [fba_pkg::WORD_BITS-1:0]         bm_rdata;
  logic                                  sm_we;
  logic [fba_pkg::SUM_AW-1:0]            sm_waddr;
  logic [fba_pkg::WORD_BITS-1:0]         sm_wdata;
  logic [fba_pkg::SUM_AW-1:0]            sm_raddr;
  logic [fba_pkg::WORD_BITS-1:0]         sm_rdata;

  logic                                  in_fire;
  logic [fba_pkg::COUNT_W-1:0]           clamp_n;
  logic [fba_pkg::SUM_AW-1:0]            top_pick;
  logic [fba_pkg::SUM_WORDS-1:0]         top_init;
  logic [fba_pkg::COUNT_W-1:0]           full_sums;
  logic [fba_pkg::BIT_W-1:0]             bit_sel;
  logic [fba_pkg::WORD_BITS-1:0]         alloc_word;
  logic [fba_pkg::WORD_BITS-1:0]         alloc_sum;
  logic                                  range_bad;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  // Clamp the reserve to the frame count
  assign clamp_n = (reserved > fba_pkg::COUNT_W'(fba_pkg::NUM_FRAMES)) ?
                   fba_pkg::COUNT_W'(fba_pkg::NUM_FRAMES) : reserved;

  assign range_bad = (s_tdata[fba_pkg::IN_DATA_W-1:fba_pkg::OFFSET_W] >=
                      (fba_pkg::IN_DATA_W - fba_pkg::OFFSET_W)'(fba_pkg::NUM_FRAMES));

  // Pick the lowest summary word that still has a non-full bitmap word
  always_comb begin
    top_pick = '0;
    for (int j = fba_pkg::SUM_WORDS - 1; j >= 0; j--) begin
      if (!top_full[j]) top_pick = fba_pkg::SUM_AW'(j);
    end
  end

  // Full summary words after a sweep with fill_n reserved frames
  assign full_sums = fill_n >> (2 * fba_pkg::BIT_W);
  always_comb begin
    for (int j = 0; j < fba_pkg::SUM_WORDS; j++) begin
      top_init[j] = (fba_pkg::COUNT_W'(j) < full_sums);
    end
  end

  // Allocation: set the lowest clear bit and mark the word full if it fills
  assign bit_sel    = fba_pkg::lowest_zero(bm_rdata);
  assign alloc_word = bm_rdata | (fba_pkg::WORD_BITS'(1) << bit_sel);
  assign alloc_sum  = sum_word | (fba_pkg::WORD_BITS'(1) << word_idx[fba_pkg::BIT_W-1:0]);

  // Drive the RAM ports from the sequencer state
  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = word_idx;
    bm_wdata = alloc_word;
    bm_raddr = word_idx;
    sm_we    = 1'b0;
    sm_waddr = sum_idx;
    sm_wdata = alloc_sum;
    sm_raddr = sum_idx;
    case (state)
      S_SWEEP: begin
        bm_we    = 1'b1;
        bm_waddr = sweep_addr;
        bm_wdata = fba_pkg::fill_pattern(
                     fba_pkg::COUNT_W'({sweep_addr, fba_pkg::BIT_W'(0)}), fill_n);
        sm_we    = (sweep_addr < fba_pkg::WORD_AW'(fba_pkg::SUM_WORDS));
        sm_waddr = sweep_addr[fba_pkg::SUM_AW-1:0];
        sm_wdata = fba_pkg::fill_pattern(
                     fba_pkg::COUNT_W'({sweep_addr[fba_pkg::SUM_AW-1:0],
                                        fba_pkg::BIT_W'(0)}),
                     fill_n >> fba_pkg::BIT_W);
      end
      S_A_BDAT: begin
        bm_we = 1'b1;
        sm_we = &alloc_word;
      end
      S_F_RD: begin
        bm_raddr = free_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
        sm_raddr = free_frame[fba_pkg::FRAME_W-1:2*fba_pkg::BIT_W];
      end
      S_F_DAT: begin
        bm_we    = 1'b1;
        bm_waddr = free_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
        bm_wdata = bm_rdata & ~(fba_pkg::WORD_BITS'(1) <<
                                free_frame[fba_pkg::BIT_W-1:0]);
        sm_we    = 1'b1;
        sm_waddr = free_frame[fba_pkg::FRAME_W-1:2*fba_pkg::BIT_W];
        sm_wdata = sm_rdata & ~(fba_pkg::WORD_BITS'(1) <<
                                free_frame[2*fba_pkg::BIT_W-1:fba_pkg::BIT_W]);
      end
      default: begin
      end
    endcase
  end

  // Sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      sweep_req  <= 1'b0;
      fill_n     <= fba_pkg::COUNT_W'(fba_pkg::RESERVED_RESET);
      count      <= fba_pkg::COUNT_W'(fba_pkg::RESERVED_RESET);
      reserved   <= fba_pkg::RESERVED_RESET;
      top_full   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) reserved <= cfg_wdata;
      if (m_tvalid && m_tready && (state != S_DONE)) m_tvalid <= 1'b0;

      case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + fba_pkg::WORD_AW'(1);
          if (sweep_addr == fba_pkg::WORD_AW'(fba_pkg::WORDS - 1)) begin
            top_full  <= top_init;
            sweep_req <= 1'b0;
            state     <= sweep_req ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            res_addr   <= '0;
            res_status <= fba_pkg::ST_OK;
            case (s_tuser)
              fba_pkg::REQ_ALLOC: begin
                if (&top_full) begin
                  res_status <= fba_pkg::ST_FULL;
                  state      <= S_DONE;
                end else begin
                  sum_idx <= top_pick;
                  state   <= S_A_SRD;
                end
              end
              fba_pkg::REQ_FREE: begin
                if (range_bad) begin
                  res_status <= fba_pkg::ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  free_frame <= s_tdata[fba_pkg::OFFSET_W +: fba_pkg::FRAME_W];
                  if (count != '0) count <= count - fba_pkg::COUNT_W'(1);
                  state <= S_F_RD;
                end
              end
              fba_pkg::REQ_CLEAR: begin
                fill_n     <= clamp_n;
                count      <= clamp_n;
                sweep_addr <= '0;
                sweep_req  <= 1'b1;
                state      <= S_SWEEP;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_A_SRD: begin
          state <= S_A_SDAT;
        end
        S_A_SDAT: begin
          sum_word <= sm_rdata;
          word_idx <= {sum_idx, fba_pkg::lowest_zero(sm_rdata)};
          state    <= S_A_BRD;
        end
        S_A_BRD: begin
          state <= S_A_BDAT;
        end
        S_A_BDAT: begin
          if (&alloc_word) top_full[sum_idx] <= &alloc_sum;
          count    <= count + fba_pkg::COUNT_W'(1);
          res_addr <= {word_idx, bit_sel, fba_pkg::OFFSET_W'(0)};
          state    <= S_DONE;
        end
        S_F_RD: begin
          state <= S_F_DAT;
        end
        S_F_DAT: begin
          top_full[free_frame[fba_pkg::FRAME_W-1:2*fba_pkg::BIT_W]] <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, count, res_status, res_addr};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  fba_ram #(
    .WIDTH (fba_pkg::WORD_BITS),
    .DEPTH (fba_pkg::WORDS)
  ) u_bitmap_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  fba_ram #(
    .WIDTH (fba_pkg::WORD_BITS),
    .DEPTH (fba_pkg::SUM_WORDS)
  ) u_summary_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  // The in-use count never passes the number of frames
  `FBA_ASSERT(a_count_bound, count <= fba_pkg::COUNT_W'(fba_pkg::NUM_FRAMES), "count over range")
  // The summary must lead an allocation to a word with a clear bit
  `FBA_ASSERT_IMP(a_word_has_room, state == S_A_BDAT, bm_rdata != '1, "summary points at full word")
  // A no-free-frame result carries address zero
  `FBA_ASSERT_IMP(a_full_addr, m_tvalid && m_tdata[29:28] == fba_pkg::ST_FULL, m_tdata[27:0] == '0, "address on full")

endmodule

// File: tb/tb.sv
// Testbench for the frame bitmap allocator: directed and random requests checked by a bitmap predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                REQ_UNKNOWN  = 2'd3;
  localparam int unsigned               PHASE_ITEMS  = 142;
  localparam int unsigned               MAX_REPORTS  = 10;
  localparam int unsigned               DRAIN_CYCLES = 40;
  localparam logic [fba_pkg::CFG_W-1:0] CFG_MAX      = '1;

  typedef struct packed {
    logic [fba_pkg::ADDR_W-1:0]   frame_address;
    logic [fba_pkg::STATUS_W-1:0] status;
    logic [fba_pkg::COUNT_W-1:0]  used_count;
  } frame_result_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [fba_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
  logic [1:0]                     s_tuser   = '0;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [fba_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_we    = 1'b0;
  logic [fba_pkg::CFG_W-1:0]      cfg_wdata = '0;

  // Predictor state: one bit per frame, count in use, reserve register
  logic [fba_pkg::WORD_BITS-1:0] frame_map [fba_pkg::WORDS];
  logic [fba_pkg::COUNT_W-1:0]   busy_frames;
  logic [fba_pkg::CFG_W-1:0]     reserve_setting;

  frame_result_t              pending_results[$];
  logic [fba_pkg::ADDR_W-1:0] held_frames[$];
  bit                         steady_flow = 1'b0;

  int mismatches  = 0;
  int n_items     = 0;
  int n_granted   = 0;
  int n_full      = 0;
  int n_freed     = 0;
  int n_range     = 0;
  int n_clears    = 0;
  int n_unknown   = 0;
  int n_settings  = 0;

  frame_bitmap_allocator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Empty the map and mark the reserved low frames used
  function automatic void reserve_frames();
    logic [fba_pkg::COUNT_W-1:0] n;
    int unsigned                 lo;
    n = (reserve_setting > fba_pkg::NUM_FRAMES) ?
        fba_pkg::COUNT_W'(fba_pkg::NUM_FRAMES) : reserve_setting;
    for (int w = 0; w < fba_pkg::WORDS; w++) begin
      lo = w * fba_pkg::WORD_BITS;
      if (n >= lo + fba_pkg::WORD_BITS) frame_map[w] = '1;
      else if (n > lo) frame_map[w] = (32'h1 << (n - lo)) - 32'h1;
      else frame_map[w] = '0;
    end
    busy_frames = n;
  endfunction

  // Apply one accepted request to the predictor and queue its result
  function automatic void predict_result(input logic [1:0] kind,
                                         input logic [fba_pkg::IN_DATA_W-1:0] addr);
    frame_result_t                 r;
    logic [fba_pkg::IN_DATA_W-1:0] idx;
    bit                            found;
    r.frame_address = '0;
    r.status        = fba_pkg::ST_OK;
    found           = 1'b0;
    idx             = addr / fba_pkg::FRAME_BYTES;
    case (kind)
      fba_pkg::REQ_ALLOC: begin
        // First fit: skip full words, then take the lowest clear bit
        for (int w = 0; w < fba_pkg::WORDS && !found; w++) begin
          if (frame_map[w] != '1) begin
            for (int b = 0; b < fba_pkg::WORD_BITS && !found; b++) begin
              if (!frame_map[w][b]) begin
                frame_map[w][b] = 1'b1;
                busy_frames++;
                r.frame_address = fba_pkg::ADDR_W'((w * fba_pkg::WORD_BITS + b) *
                                                   fba_pkg::FRAME_BYTES);
                found = 1'b1;
              end
            end
          end
        end
        if (found) begin
          held_frames.push_back(r.frame_address);
          n_granted++;
        end else begin
          r.status = fba_pkg::ST_FULL;
          n_full++;
        end
      end
      fba_pkg::REQ_FREE: begin
        if (idx < fba_pkg::NUM_FRAMES) begin
          frame_map[idx[fba_pkg::FRAME_W-1:fba_pkg::BIT_W]][idx[fba_pkg::BIT_W-1:0]] = 1'b0;
          if (busy_frames != 0) busy_frames--;
          n_freed++;
        end else begin
          r.status = fba_pkg::ST_RANGE;
          n_range++;
        end
      end
      fba_pkg::REQ_CLEAR: begin
        reserve_frames();
        held_frames.delete();
        n_clears++;
      end
      default: n_unknown++;
    endcase
    r.used_count = busy_frames;
    pending_results.push_back(r);
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $realtime, what);
  endfunction

  // Send one item, idling at random before it, and predict it once accepted
  task automatic send_item(input logic [1:0] kind, input logic [fba_pkg::IN_DATA_W-1:0] addr);
    while (!steady_flow && $urandom_range(0, 99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= addr;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    predict_result(kind, addr);
    n_items++;
  endtask

  // Hold the sender until every queued result has arrived
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the reserve register while the block is idle
  task automatic set_reserve(input logic [fba_pkg::CFG_W-1:0] value);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    reserve_setting = value;
    n_settings++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Check each result against the oldest prediction; stall the receiver at random
  always @(posedge clk) begin : check_results
    frame_result_t got;
    frame_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got.frame_address = m_tdata[fba_pkg::ADDR_W-1:0];
      got.status        = m_tdata[fba_pkg::ADDR_W+fba_pkg::STATUS_W-1:fba_pkg::ADDR_W];
      got.used_count    = m_tdata[fba_pkg::ADDR_W+fba_pkg::STATUS_W+fba_pkg::COUNT_W-1:
                                  fba_pkg::ADDR_W+fba_pkg::STATUS_W];
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result addr=%h status=%0d used=%0d",
                                got.frame_address, got.status, got.used_count));
      end else begin
        want = pending_results.pop_front();
        if (got.frame_address !== want.frame_address || got.status !== want.status ||
            got.used_count !== want.used_count) begin
          note_mismatch($sformatf("addr=%h/%h status=%0d/%0d used=%0d/%0d (expected/actual)",
                                  want.frame_address, got.frame_address, want.status,
                                  got.status, want.used_count, got.used_count));
        end
      end
    end
    m_tready <= steady_flow || ($urandom_range(0, 99) >= 33);
  end

  // Reset defaults: first megabyte reserved, frees of free frames, range limits
  task automatic test_reset_defaults();
    send_item(fba_pkg::REQ_ALLOC, '0);
    send_item(fba_pkg::REQ_FREE, 32'h0010_0000);
    send_item(fba_pkg::REQ_FREE, 32'h0010_0ABC);
    send_item(fba_pkg::REQ_ALLOC, '0);
    send_item(fba_pkg::REQ_FREE, 32'h0FFF_FFFF);
    send_item(fba_pkg::REQ_FREE, 32'h1000_0000);
    send_item(fba_pkg::REQ_FREE, 32'hFFFF_FFFF);
    send_item(REQ_UNKNOWN, 32'hFFFF_FFFF);
    send_item(fba_pkg::REQ_FREE, 32'h0000_0000);
    send_item(fba_pkg::REQ_ALLOC, '0);
  endtask

  // No reserved frames: frame zero, count saturating at zero, delayed register effect
  task automatic test_low_frames();
    set_reserve('0);
    send_item(fba_pkg::REQ_CLEAR, '0);
    send_item(fba_pkg::REQ_ALLOC, '0);
    send_item(fba_pkg::REQ_ALLOC, '0);
    send_item(fba_pkg::REQ_FREE, 32'h0000_0000);
    send_item(fba_pkg::REQ_FREE, 32'h0000_1000);
    send_item(fba_pkg::REQ_FREE, 32'h0000_0FFF);
    set_reserve(fba_pkg::CFG_W'(5));
    send_item(fba_pkg::REQ_ALLOC, '0);
    send_item(fba_pkg::REQ_CLEAR, '0);
    send_item(fba_pkg::REQ_ALLOC, '0);
  endtask

  // Oversized reserve clamps to the whole map: full refusals and the top frame
  task automatic test_full_map();
    set_reserve(CFG_MAX);
    send_item(fba_pkg::REQ_CLEAR, 32'hFFFF_FFFF);
    send_item(fba_pkg::REQ_ALLOC, '0);
    send_item(fba_pkg::REQ_FREE, 32'h0FFF_F000);
    send_item(fba_pkg::REQ_ALLOC, '0);
    send_item(fba_pkg::REQ_ALLOC, '0);
  endtask

  // Phases of mostly alloc/free traffic under a range of reserve settings
  task automatic test_random_traffic();
    logic [fba_pkg::CFG_W-1:0]     settings [9];
    logic [1:0]                    kind;
    logic [fba_pkg::IN_DATA_W-1:0] addr;
    int                            pick;
    int                            slot;
    settings = '{fba_pkg::CFG_W'(256), fba_pkg::CFG_W'(0), fba_pkg::CFG_W'(31),
                 fba_pkg::CFG_W'(1024), fba_pkg::CFG_W'(65535),
                 fba_pkg::CFG_W'(fba_pkg::NUM_FRAMES), fba_pkg::CFG_W'(40000), CFG_MAX,
                 fba_pkg::CFG_W'($urandom_range(0, 65536))};
    for (int p = 0; p < 9; p++) begin
      set_reserve(settings[p]);
      steady_flow = (p == 3);
      send_item(fba_pkg::REQ_CLEAR, $urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        addr = $urandom;
        if (pick < 45 || (pick < 75 && held_frames.size() == 0)) begin
          kind = fba_pkg::REQ_ALLOC;
        end else if (pick < 75) begin
          // Return a frame handed out earlier, sometimes by an unaligned address
          slot = $urandom_range(0, held_frames.size() - 1);
          addr = {4'h0, held_frames[slot]} | (pick[0] ? {20'h0, addr[11:0]} : '0);
          held_frames[slot] = held_frames[held_frames.size() - 1];
          held_frames.pop_back();
          kind = fba_pkg::REQ_FREE;
        end else if (pick < 83) begin
          addr = {4'h0, addr[27:0]};
          kind = fba_pkg::REQ_FREE;
        end else if (pick < 89) begin
          kind = fba_pkg::REQ_FREE;
        end else if (pick < 94) begin
          addr = {4'($urandom_range(1, 15)), addr[27:0]};
          kind = fba_pkg::REQ_FREE;
        end else if (pick < 98) begin
          kind = REQ_UNKNOWN;
        end else begin
          kind = fba_pkg::REQ_CLEAR;
        end
        send_item(kind, addr);
        if ($urandom_range(0, 99) == 0) wait_for_results();
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    reserve_setting = fba_pkg::RESERVED_RESET;
    reserve_frames();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_low_frames();
    test_full_map();
    test_random_traffic();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("Run covered %0d requests over %0d reserve settings: %0d grants, %0d full refusals,",
             n_items, n_settings, n_granted, n_full);
    $display("  %0d frees, %0d out-of-range frees, %0d clears, %0d unknown kinds; %0d mismatches.",
             n_freed, n_range, n_clears, n_unknown, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
